// ----- hdl/etc1_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package etc1_pkg;

   // Configuration register indexes
   localparam logic CSR_ALLOW_DIFF  = 1'b0;
   localparam logic CSR_ALLOW_INDIV = 1'b1;

   localparam int PIX_CNT_W = 4;
   localparam logic [PIX_CNT_W-1:0] PIX_LAST = 4'd15;

   // Intensity modifier magnitudes, per table codeword
   localparam logic [7:0] MOD_SMALL_TAB [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
                                                8'd18, 8'd24, 8'd33, 8'd47};
   localparam logic [7:0] MOD_LARGE_TAB [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
                                                8'd60, 8'd80, 8'd106, 8'd183};

   // Decoded block, held while its pixels are sent
   typedef struct packed {
      logic        ok;
      logic        flip;
      logic [2:0]  cwd1;
      logic [2:0]  cwd2;
      logic [7:0]  red1;
      logic [7:0]  green1;
      logic [7:0]  blue1;
      logic [7:0]  red2;
      logic [7:0]  green2;
      logic [7:0]  blue2;
      logic [31:0] index_word;
   } block_type;

   // One result beat
   typedef struct packed {
      logic [1:0] pixel_x;
      logic [1:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       decode_ok;
      logic       last;
   } pixel_type;

endpackage

`default_nettype wire

// ----- hdl/etc1_block_decoder.sv -----
// ETC1 texture block decoder.
// Request channel (req_valid/req_stall): one beat carries a 64-bit block as
// colour_word (bytes 0..3) and index_word (bytes 4..7). Result channel
// (rsp_valid/rsp_stall): one beat per pixel in raster order, row 0 first,
// with rsp_last on the sixteenth. A block in a disabled mode, or with a
// differential delta out of range, yields a single beat with decode_ok low
// and last high. Register port (csr_valid/csr_ready, always ready): index 0
// enables differential mode, index 1 individual mode; write only while idle.
// The block register loads when the block is accepted, and the first pixel
// then moves from it into the result register, which drives the outputs.
// Throughput: one pixel per cycle while the receiver does not stall; the
// next block is taken in the cycle its predecessor's last pixel moves to the
// result register, so blocks stream without gaps.
// When the receiver stalls, the result register holds its beat, the pixel
// counter stops and req_stall rises once the block register is busy.
// Reset (synchronous, active high) empties both registers and enables both
// modes.
`timescale 1ns / 1ps
`default_nettype none

module etc1_block_decoder
   import etc1_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_colour_word,
   input  wire logic [31:0] req_index_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_pixel_x,
   output logic [1:0]       rsp_pixel_y,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_decode_ok,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   logic                 allow_diff_ff, allow_diff_in;
   logic                 allow_indiv_ff, allow_indiv_in;
   block_type            blk_ff, blk_in;
   logic                 blk_valid_ff, blk_valid_in;
   logic [PIX_CNT_W-1:0] pix_cnt_ff, pix_cnt_in;
   pixel_type            rsp_pix_ff, rsp_pix_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_adv, emit, blk_done, accept;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      allow_diff_in  = allow_diff_ff;
      allow_indiv_in = allow_indiv_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALLOW_DIFF:  allow_diff_in  = csr_wdata;
            CSR_ALLOW_INDIV: allow_indiv_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode base colours on the way into the block register
   etc1_base_decode u_base (
      .colour_word (req_colour_word),
      .index_word  (req_index_word),
      .allow_diff  (allow_diff_ff),
      .allow_indiv (allow_indiv_ff),
      .blk         (blk_in)
   );

   // Pixel for the current count
   etc1_pixel_gen u_pix (
      .blk     (blk_ff),
      .pix_cnt (pix_cnt_ff),
      .pix     (rsp_pix_in)
   );

   // Handshake control
   assign out_adv   = ~rsp_valid_ff | ~rsp_stall;
   assign emit      = blk_valid_ff & out_adv;
   assign blk_done  = ~blk_ff.ok | (pix_cnt_ff == PIX_LAST);
   assign req_stall = blk_valid_ff & ~(emit & blk_done);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      blk_valid_in = blk_valid_ff;
      pix_cnt_in   = pix_cnt_ff;
      if (accept) begin
         blk_valid_in = 1'b1;
         pix_cnt_in   = '0;
      end else if (emit && blk_done) begin
         blk_valid_in = 1'b0;
         pix_cnt_in   = '0;
      end else if (emit) begin
         pix_cnt_in   = pix_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      if (emit)         rsp_valid_in = 1'b1;
      else if (out_adv) rsp_valid_in = 1'b0;
      else              rsp_valid_in = rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_diff_ff  <= 1'b1;
         allow_indiv_ff <= 1'b1;
         blk_valid_ff   <= 1'b0;
         pix_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         allow_diff_ff  <= allow_diff_in;
         allow_indiv_ff <= allow_indiv_in;
         blk_valid_ff   <= blk_valid_in;
         pix_cnt_ff     <= pix_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers: load the block on accept, the beat on emit
   always_ff @(posedge clock) begin
      if (accept) blk_ff     <= blk_in;
      if (emit)   rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_x   = rsp_pix_ff.pixel_x;
   assign rsp_pixel_y   = rsp_pix_ff.pixel_y;
   assign rsp_red       = rsp_pix_ff.red;
   assign rsp_green     = rsp_pix_ff.green;
   assign rsp_blue      = rsp_pix_ff.blue;
   assign rsp_decode_ok = rsp_pix_ff.decode_ok;
   assign rsp_last      = rsp_pix_ff.last;

   // Checks
   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !blk_valid_ff |-> pix_cnt_ff == '0)
      else $error("pixel counter not at zero while block register empty");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> blk_valid_ff && pix_cnt_ff == '0)
      else $error("accepted block not loaded at pixel zero");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pix_ff.decode_ok |-> rsp_pix_ff.last)
      else $error("rejected block beat not flagged last");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pix_ff.decode_ok && rsp_pix_ff.last
         |-> rsp_pix_ff.pixel_x == 2'd3 && rsp_pix_ff.pixel_y == 2'd3)
      else $error("last pixel beat is not the bottom-right corner");

endmodule

`default_nettype wire

// ----- hdl/etc1_base_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etc1_base_decode
   import etc1_pkg::*;
(
   input  wire logic [31:0] colour_word,
   input  wire logic [31:0] index_word,
   input  wire logic        allow_diff,
   input  wire logic        allow_indiv,
   output block_type        blk
);

   logic       diff;
   logic [7:0] chan_byte [3];
   logic [6:0] sum5      [3];
   logic [7:0] base1     [3];
   logic [7:0] base2     [3];
   logic [2:0] overflow;

   assign diff = colour_word[1];

   // Expand the two base colours for each channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         chan_byte[c] = colour_word[31-8*c -: 8];
         sum5[c] = {2'b00, chan_byte[c][7:3]} + {{4{chan_byte[c][2]}}, chan_byte[c][2:0]};
         overflow[c] = diff & (sum5[c][6] | sum5[c][5]);
         if (diff) begin
            base1[c] = {chan_byte[c][7:3], chan_byte[c][7:5]};
            base2[c] = {sum5[c][4:0], sum5[c][4:2]};
         end else begin
            base1[c] = {chan_byte[c][7:4], chan_byte[c][7:4]};
            base2[c] = {chan_byte[c][3:0], chan_byte[c][3:0]};
         end
      end
   end

   // Reject a disabled mode or a delta that leaves the 5-bit range
   assign blk.ok         = (diff ? allow_diff : allow_indiv) & ~(|overflow);
   assign blk.flip       = colour_word[0];
   assign blk.cwd1       = colour_word[7:5];
   assign blk.cwd2       = colour_word[4:2];
   assign blk.red1       = base1[0];
   assign blk.green1     = base1[1];
   assign blk.blue1      = base1[2];
   assign blk.red2       = base2[0];
   assign blk.green2     = base2[1];
   assign blk.blue2      = base2[2];
   assign blk.index_word = index_word;

endmodule

`default_nettype wire

// ----- hdl/etc1_pixel_gen.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etc1_pixel_gen
   import etc1_pkg::*;
(
   input  wire block_type             blk,
   input  wire logic [PIX_CNT_W-1:0] pix_cnt,
   output pixel_type                  pix
);

   logic [1:0] px;
   logic [1:0] py;
   logic [3:0] bit_sel;
   logic [1:0] idx;
   logic       second;
   logic [2:0] cwd;
   logic [7:0] mag;

   // Add a signed modifier and clamp to 0..255
   function automatic logic [7:0] sat_add(input logic [7:0] base, input logic [7:0] m,
                                          input logic neg);
      logic [9:0] s;
      s = neg ? ({2'b00, base} - {2'b00, m}) : ({2'b00, base} + {2'b00, m});
      if (s[9])      return 8'd0;
      else if (s[8]) return 8'hFF;
      else           return s[7:0];
   endfunction

   assign py      = pix_cnt[3:2];
   assign px      = pix_cnt[1:0];
   assign bit_sel = {px, py};
   assign idx     = {blk.index_word[16 + bit_sel], blk.index_word[bit_sel]};
   assign second  = blk.flip ? py[1] : px[1];
   assign cwd     = second ? blk.cwd2 : blk.cwd1;
   assign mag     = idx[0] ? MOD_LARGE_TAB[cwd] : MOD_SMALL_TAB[cwd];

   // Build the beat; a rejected block gives one zero beat
   always_comb begin
      if (blk.ok) begin
         pix.pixel_x   = px;
         pix.pixel_y   = py;
         pix.red       = sat_add(second ? blk.red2   : blk.red1,   mag, idx[1]);
         pix.green     = sat_add(second ? blk.green2 : blk.green1, mag, idx[1]);
         pix.blue      = sat_add(second ? blk.blue2  : blk.blue1,  mag, idx[1]);
         pix.decode_ok = 1'b1;
         pix.last      = (pix_cnt == PIX_LAST);
      end else begin
         pix.pixel_x   = 2'd0;
         pix.pixel_y   = 2'd0;
         pix.red       = 8'd0;
         pix.green     = 8'd0;
         pix.blue      = 8'd0;
         pix.decode_ok = 1'b0;
         pix.last      = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ----- sim/tb_etc1_block_decoder.sv -----
`timescale 1ns / 1ps

module tb_etc1_block_decoder;
   import etc1_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic [31:0] colour_word;
      logic [31:0] index_word;
   } block_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_colour_word = '0;
   logic [31:0] req_index_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_pixel_x;
   logic [1:0]  rsp_pixel_y;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_decode_ok;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;

   // Mirror of the mode enables, updated on each register write beat
   logic allow_diff_q = 1'b1;
   logic allow_indiv_q = 1'b1;

   block_beat_type blocks_to_send[$];
   pixel_type      expected_pixels[$];
   int             blocks_in_flight = 0;
   int             mismatches = 0;
   int             cycle_count = 0;

   etc1_block_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_colour_word (req_colour_word),
      .req_index_word  (req_index_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_decode_ok   (rsp_decode_ok),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Signed intensity offset: index bit 0 picks the large step, bit 1 negates
   function automatic int intensity_mod(input logic [2:0] cwd, input logic [1:0] sel);
      int mag;
      case (cwd)
         3'd0: mag = sel[0] ? 8 : 2;
         3'd1: mag = sel[0] ? 17 : 5;
         3'd2: mag = sel[0] ? 29 : 9;
         3'd3: mag = sel[0] ? 42 : 13;
         3'd4: mag = sel[0] ? 60 : 18;
         3'd5: mag = sel[0] ? 80 : 24;
         3'd6: mag = sel[0] ? 106 : 33;
         default: mag = sel[0] ? 183 : 47;
      endcase
      return sel[1] ? -mag : mag;
   endfunction

   function automatic logic [7:0] clamp8(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // Work out the pixel beats of one block and queue them
   function automatic void decode_block(input logic [31:0] cw, input logic [31:0] iw);
      logic [7:0] ctl;
      logic [7:0] b;
      logic [1:0] sel;
      logic       diff;
      logic       flip;
      logic       ok;
      logic       second;
      int         base1[3];
      int         base2[3];
      int         r5;
      int         delta;
      int         s5;
      int         m;
      int         p;
      pixel_type  pix;
      ctl = cw[7:0];
      diff = ctl[1];
      flip = ctl[0];
      ok = diff ? allow_diff_q : allow_indiv_q;
      for (int c = 0; c < 3; c++) begin
         b = cw[31-8*c -: 8];
         if (diff) begin
            r5 = int'(b[7:3]);
            delta = b[2] ? int'(b[1:0]) - 4 : int'(b[1:0]);
            s5 = r5 + delta;
            if (s5 < 0 || s5 > 31) ok = 1'b0;
            base1[c] = (r5 << 3) | (r5 >> 2);
            base2[c] = (s5 << 3) | (s5 >> 2);
         end else begin
            base1[c] = (int'(b[7:4]) << 4) | int'(b[7:4]);
            base2[c] = (int'(b[3:0]) << 4) | int'(b[3:0]);
         end
      end
      // Rejected block: a single zero beat that closes the block
      if (!ok) begin
         pix = '0;
         pix.last = 1'b1;
         expected_pixels.push_back(pix);
         return;
      end
      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            p = x * 4 + y;
            sel = {iw[16+p], iw[p]};
            second = flip ? (y >= 2) : (x >= 2);
            m = intensity_mod(second ? ctl[4:2] : ctl[7:5], sel);
            pix.pixel_x = x[1:0];
            pix.pixel_y = y[1:0];
            pix.red = clamp8((second ? base2[0] : base1[0]) + m);
            pix.green = clamp8((second ? base2[1] : base1[1]) + m);
            pix.blue = clamp8((second ? base2[2] : base1[2]) + m);
            pix.decode_ok = 1'b1;
            pix.last = (x == 3 && y == 3);
            expected_pixels.push_back(pix);
         end
      end
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic block_beat_type random_block();
      block_beat_type blk;
      logic [7:0]     b;
      for (int c = 0; c < 3; c++) begin
         b = 8'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: b = 8'h00;
               1: b = 8'hFF;
               2: b = 8'h07;
               default: b = 8'hF8;
            endcase
         end
         blk.colour_word[31-8*c -: 8] = b;
      end
      blk.colour_word[7:0] = 8'($urandom);
      blk.index_word = $urandom;
      if ($urandom_range(0, 19) == 0) blk.index_word = $urandom_range(0, 1) ? '1 : '0;
      return blk;
   endfunction

   task automatic queue_block(input logic [31:0] cw, input logic [31:0] iw);
      blocks_to_send.push_back('{colour_word: cw, index_word: iw});
      blocks_in_flight++;
   endtask

   task automatic queue_random(input int n);
      repeat (n) begin
         blocks_to_send.push_back(random_block());
         blocks_in_flight++;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (blocks_in_flight != 0 || expected_pixels.size() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ALLOW_DIFF) allow_diff_q = val;
      else allow_indiv_q = val;
   endtask

   // Change the mode enables only once the decoder has gone quiet
   task automatic apply_modes(input logic diff_en, input logic indiv_en);
      wait_drained();
      repeat (4) @(posedge clock);
      write_csr(CSR_ALLOW_DIFF, diff_en);
      write_csr(CSR_ALLOW_INDIV, indiv_en);
   endtask

   // One block of each mode, to hit the disabled-mode rejection
   task automatic queue_mode_pair();
      queue_block(32'h12345664, $urandom);
      queue_block(32'h80808082, $urandom);
   endtask

   // Sender: hold a stalled beat, otherwise idle or take the next block
   always @(posedge clock) begin : drive_blocks
      block_beat_type nxt;
      logic           accepted;
      int             send_gap;
      int             send_calm;
      logic           drain_hold;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
         drain_hold = 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            decode_block(req_colour_word, req_index_word);
            blocks_in_flight--;
         end
         if (drain_hold && expected_pixels.size() == 0) drain_hold = 1'b0;
         if (req_valid && !accepted) begin
            // hold the stalled beat
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (drain_hold || blocks_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = blocks_to_send.pop_front();
            req_valid <= 1'b1;
            req_colour_word <= nxt.colour_word;
            req_index_word <= nxt.index_word;
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
            send_gap = (send_calm > 0) ? 0 : pick_gap();
            if ($urandom_range(0, 79) == 0) drain_hold = 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: check each accepted beat, then pick the next stall
   always @(posedge clock) begin : watch_pixels
      pixel_type want;
      int        stall_left;
      int        stall_calm;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         stall_calm = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result beat with none expected (x %0d y %0d ok %0d)",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_decode_ok);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", want.pixel_x, rsp_pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_pixel_y);
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("decode_ok", want.decode_ok, rsp_decode_ok);
               check_field("last", want.last, rsp_last);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_calm > 0) stall_calm--;
            else if ($urandom_range(0, 59) == 0) stall_calm = $urandom_range(30, 150);
            else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [2:0] k3;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Individual mode: all zero, then saturation high and low, both split directions
      queue_block(32'h00000000, 32'h00000000);
      queue_block(32'hFFFFFFFC, 32'h0000FFFF);
      queue_block(32'h000000FD, 32'hFFFF0000);
      queue_block(32'hF00FF0E1, 32'hA5A55A5A);
      // Differential mode at the delta extremes without overflow
      queue_block(32'hFC038002, 32'h12345678);
      queue_block(32'hFC0380FF, 32'hFFFFFFFF);
      // Delta overflow below zero and above 31 on different channels
      queue_block(32'h07808002, $urandom);
      queue_block(32'h8080F903, $urandom);
      queue_block(32'h80FB8022, $urandom);
      // Every table codeword in both halves, modes and splits mixed
      for (int k = 0; k < 8; k++) begin
         k3 = 3'(k);
         queue_block(($urandom & 32'hF8F8F800) | {24'd0, k3, ~k3, k3[0], k3[1]}, $urandom);
      end
      queue_random(300);

      apply_modes(1'b0, 1'b1);
      queue_mode_pair();
      queue_random(60);

      apply_modes(1'b1, 1'b0);
      queue_mode_pair();
      queue_random(60);

      apply_modes(1'b0, 1'b0);
      queue_mode_pair();
      queue_random(30);

      apply_modes(1'b1, 1'b1);
      queue_mode_pair();
      queue_random(50);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
